// ===== rtl/core/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types, codes and defaults of the task dependency tracker.
// ----------------------------------------------------------------------------
package tdt_pkg;

	localparam int DEF_SLOTS      = 64;
	localparam int DEF_SUCCESSORS = 8;
	localparam int DEF_MAX_TASKS  = 128;
	localparam int DEF_DEPS       = 4;
	localparam int MAX_RESULTS    = 9;
	localparam int DEP_FIELDS     = 4;
	localparam int SLOT_W_MAX     = 10;

	localparam logic [1:0] ACT_CREATE  = 2'd0;
	localparam logic [1:0] ACT_DONE    = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_SUCC_FULL = 2'd3;

	localparam logic KIND_ACK      = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  group;
		logic [15:0] function_id;
		logic [31:0] argument;
		logic [7:0]  task_count;
		logic [2:0]  dep_count;
		logic [5:0]  dep_first;
		logic [5:0]  dep_second;
		logic [5:0]  dep_third;
		logic [5:0]  dep_fourth;
		logic [5:0]  handle;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [5:0]  new_handle;
		logic [5:0]  dispatch_handle;
		logic [15:0] dispatch_function;
		logic [31:0] dispatch_argument;
		logic [7:0]  dispatch_count;
		logic [5:0]  dispatch_group;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]                                 action;
		logic                                       bad_count;
		logic [2:0]                                 dep_n;
		logic [DEP_FIELDS-1:0][SLOT_W_MAX-1:0]      dep;
		logic [SLOT_W_MAX-1:0]                      handle;
		logic [5:0]                                 group;
		logic [15:0]                                function_id;
		logic [31:0]                                argument;
		logic [7:0]                                 task_count;
	} cmd_t;

endpackage

// ===== rtl/core/tdt_front.sv =====
// ----------------------------------------------------------------------------
// tdt_front
// Accepts input items, reduces handles, checks the task count and clamps the
// dependency count, then queues the classified command for the back end.
// ----------------------------------------------------------------------------
module tdt_front import tdt_pkg::*; #(
	parameter int SLOTS     = DEF_SLOTS,
	parameter int MAX_TASKS = DEF_MAX_TASKS,
	parameter int DEPS      = DEF_DEPS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  cmd_valid,
	input  logic  cmd_ready,
	output cmd_t  cmd
);

	localparam int SW  = $clog2(SLOTS);
	localparam int LIM = (DEPS < DEP_FIELDS) ? DEPS : DEP_FIELDS;

	logic [SW-1:0] mod_tab [64];

	for (genvar v = 0; v < 64; v++) begin : g_mod
		assign mod_tab[v] = SW'(v % SLOTS);
	end

	cmd_t cls;
	cmd_t fifo_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	always_comb begin
		cls             = '0;
		cls.action      = item.action;
		cls.bad_count   = (item.task_count == 8'd0) || (32'(item.task_count) > 32'(MAX_TASKS));
		cls.dep_n       = (item.dep_count > 3'(LIM)) ? 3'(LIM) : item.dep_count;
		cls.dep[0]      = SLOT_W_MAX'(mod_tab[item.dep_first]);
		cls.dep[1]      = SLOT_W_MAX'(mod_tab[item.dep_second]);
		cls.dep[2]      = SLOT_W_MAX'(mod_tab[item.dep_third]);
		cls.dep[3]      = SLOT_W_MAX'(mod_tab[item.dep_fourth]);
		cls.handle      = SLOT_W_MAX'(mod_tab[item.handle]);
		cls.group       = item.group;
		cls.function_id = item.function_id;
		cls.argument    = item.argument;
		cls.task_count  = item.task_count;
	end

	assign item_ready = (cnt_q != 2'd2);
	assign push       = item_valid && item_ready;
	assign cmd_valid  = (cnt_q != 2'd0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

endmodule

// ===== rtl/core/tdt_back.sv =====
// ----------------------------------------------------------------------------
// tdt_back
// Sequencer over the slot table: allocation scan, successor linking,
// completion scan and result queue. Every table is read through a read
// register at one address a cycle.
// ----------------------------------------------------------------------------
module tdt_back import tdt_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int SUCCESSORS = DEF_SUCCESSORS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  cmd_t    cmd,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int JW = (SUCCESSORS > 1) ? $clog2(SUCCESSORS) : 1;
	localparam int EW = $clog2(MAX_RESULTS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_ACT   = 4'd2;
	localparam logic [3:0] S_DEPS  = 4'd3;
	localparam logic [3:0] S_DCHK  = 4'd4;
	localparam logic [3:0] S_ALLOC = 4'd5;
	localparam logic [3:0] S_ACHK  = 4'd6;
	localparam logic [3:0] S_HWAIT = 4'd7;
	localparam logic [3:0] S_LINK  = 4'd8;
	localparam logic [3:0] S_LCHK  = 4'd9;
	localparam logic [3:0] S_SCAN  = 4'd10;
	localparam logic [3:0] S_SREAD = 4'd11;
	localparam logic [3:0] S_STGT  = 4'd12;
	localparam logic [3:0] S_DROP  = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;

	// slot table
	logic [1:0]            ref_q   [SLOTS];
	logic [SUCCESSORS-1:0] sv_q    [SLOTS];
	logic [2:0]            start_q [SLOTS];
	logic [7:0]            pend_q  [SLOTS];
	logic [7:0]            tcnt_q  [SLOTS];
	logic [5:0]            grp_q   [SLOTS];
	logic [15:0]           func_q  [SLOTS];
	logic [31:0]           arg_q   [SLOTS];
	logic [SW-1:0]         succ_q  [SLOTS][SUCCESSORS];
	logic [SW-1:0]         next_free_q;
	logic [CW-1:0]         live_cnt_q;

	// read registers
	logic [1:0]            ref_rd_q;
	logic [SUCCESSORS-1:0] sv_rd_q;
	logic [7:0]            pend_rd_q;
	logic [2:0]            start_rd_q;
	logic [7:0]            tcnt_rd_q;
	logic [5:0]            grp_rd_q;
	logic [15:0]           func_rd_q;
	logic [31:0]           arg_rd_q;
	logic [SW-1:0]         succ_rd_q;

	// sequencer
	logic [3:0]            state_q;
	cmd_t                  cmd_q;
	logic [2:0]            dep_i_q;
	logic [SW-1:0]         list_q [DEP_FIELDS];
	logic [2:0]            nl_q;
	logic [1:0]            link_k_q;
	logic                  par_phase_q, has_par_q, ret_link_q, disp_h_q;
	logic [SW-1:0]         parent_q, h_q, ptr_q, scan_s_q, t_q;
	logic [SUCCESSORS-1:0] scan_sv_q;
	logic [EW-1:0]         emit_q;
	logic [1:0]            status_q;
	logic [5:0]            newh_q;

	// result queue
	result_t    of_q [2];
	logic       of_wr_q, of_rd_q;
	logic [1:0] of_cnt_q;
	logic       push, push_ok, pop;
	result_t    push_d;

	// decode
	logic [SW-1:0]         d_dep, lk, hd, ra, tgt, ptr_nx;
	logic [JW-1:0]         j_free, sc_i;
	logic                  sc_any, sv_full, hold, link_last, can_emit, alloc_ok;
	logic [7:0]            newp;
	logic [SUCCESSORS-1:0] sv_link;

	assign d_dep     = cmd_q.dep[dep_i_q[1:0]][SW-1:0];
	assign lk        = list_q[link_k_q];
	assign hd        = cmd_q.handle[SW-1:0];
	assign newp      = (pend_rd_q == 8'd255) ? 8'd254 : pend_rd_q;
	assign sv_full   = &sv_rd_q;
	assign sv_link   = sv_rd_q | (SUCCESSORS'(1) << j_free);
	assign link_last = ({1'b0, link_k_q} + 3'd1 == nl_q);
	assign can_emit  = (32'(emit_q) < 32'(MAX_RESULTS - 1));
	assign ptr_nx    = (32'(ptr_q) == SLOTS - 1) ? '0 : ptr_q + SW'(1);
	assign push_ok   = (of_cnt_q != 2'd2);
	assign alloc_ok  = (state_q == S_ACHK) && (ref_rd_q == 2'd0);
	assign tgt       = (state_q == S_SREAD) ? succ_rd_q : t_q;

	always_comb begin
		j_free = '0;
		for (int i = SUCCESSORS - 1; i >= 0; i--) begin
			if (!sv_rd_q[i]) j_free = JW'(i);
		end
	end

	always_comb begin
		sc_i   = '0;
		sc_any = |scan_sv_q;
		for (int i = SUCCESSORS - 1; i >= 0; i--) begin
			if (scan_sv_q[i]) sc_i = JW'(i);
		end
	end

	always_comb begin
		case (state_q)
			S_DEPS, S_DCHK: ra = d_dep;
			S_ALLOC, S_ACHK: ra = ptr_q;
			S_LINK, S_LCHK: ra = lk;
			S_SCAN, S_SREAD, S_STGT, S_DROP: ra = scan_s_q;
			default: ra = hd;
		endcase
	end

	always_ff @(posedge clk) begin
		ref_rd_q   <= ref_q[ra];
		sv_rd_q    <= sv_q[ra];
		pend_rd_q  <= pend_q[ra];
		start_rd_q <= start_q[tgt];
		tcnt_rd_q  <= tcnt_q[tgt];
		grp_rd_q   <= grp_q[tgt];
		func_rd_q  <= func_q[tgt];
		arg_rd_q   <= arg_q[tgt];
		succ_rd_q  <= succ_q[scan_s_q][sc_i];
	end

	always_comb begin
		push   = 1'b0;
		push_d = '0;
		if (state_q == S_FIN) begin
			push = 1'b1;
			if (disp_h_q) begin
				push_d.kind              = KIND_DISPATCH;
				push_d.dispatch_handle   = 6'(t_q);
				push_d.dispatch_function = func_rd_q;
				push_d.dispatch_argument = arg_rd_q;
				push_d.dispatch_count    = tcnt_rd_q;
				push_d.dispatch_group    = grp_rd_q;
			end else begin
				push_d.kind       = KIND_ACK;
				push_d.status     = status_q;
				push_d.new_handle = newh_q;
				push_d.last       = 1'b1;
			end
		end else if (state_q == S_STGT && start_rd_q == 3'd1 && can_emit) begin
			push                     = 1'b1;
			push_d.kind              = KIND_DISPATCH;
			push_d.dispatch_handle   = 6'(t_q);
			push_d.dispatch_function = func_rd_q;
			push_d.dispatch_argument = arg_rd_q;
			push_d.dispatch_count    = tcnt_rd_q;
			push_d.dispatch_group    = grp_rd_q;
		end
	end

	assign hold      = push && !push_ok;
	assign cmd_ready = (state_q == S_IDLE);

	// table writes, one port each
	logic            ref_we, sv_we, start_we, pend_we, info_we, succ_we;
	logic [SW-1:0]   ref_wa, sv_wa, start_wa, pend_wa, info_wa;
	logic [1:0]      ref_wd;
	logic [SUCCESSORS-1:0] sv_wd;
	logic [2:0]      start_wd;
	logic [7:0]      pend_wd, tcnt_wd;
	logic [5:0]      grp_wd;
	logic [15:0]     func_wd;
	logic [31:0]     arg_wd;
	logic            live_inc, live_dec;

	always_comb begin
		ref_we = 1'b0; ref_wa = '0; ref_wd = '0;
		sv_we = 1'b0; sv_wa = '0; sv_wd = '0;
		start_we = 1'b0; start_wa = '0; start_wd = '0;
		pend_we = 1'b0; pend_wa = '0; pend_wd = '0;
		info_we = 1'b0; info_wa = ptr_q;
		tcnt_wd = '0; grp_wd = cmd_q.group; func_wd = '0; arg_wd = '0;
		succ_we = 1'b0;
		live_inc = 1'b0; live_dec = 1'b0;
		case (state_q)
			S_ACT: begin
				if (cmd_q.action == ACT_DONE && ref_rd_q != 2'd0 && pend_rd_q != 8'd0) begin
					pend_we = 1'b1; pend_wa = hd; pend_wd = pend_rd_q - 8'd1;
				end else if (cmd_q.action == ACT_RELEASE && ref_rd_q != 2'd0) begin
					ref_we = 1'b1; ref_wa = hd; ref_wd = ref_rd_q - 2'd1;
					live_dec = (ref_rd_q == 2'd1);
				end
			end
			S_ACHK: begin
				if (ref_rd_q == 2'd0) begin
					live_inc = 1'b1;
					sv_we = 1'b1; sv_wa = ptr_q; sv_wd = '0;
					ref_we = 1'b1; ref_wa = ptr_q;
					start_we = 1'b1; start_wa = ptr_q;
					pend_we = 1'b1; pend_wa = ptr_q;
					info_we = 1'b1;
					if (par_phase_q) begin
						ref_wd = 2'd1; start_wd = 3'd0; pend_wd = 8'd0;
					end else begin
						ref_wd = 2'd2; start_wd = nl_q; pend_wd = cmd_q.task_count;
						tcnt_wd = cmd_q.task_count; func_wd = cmd_q.function_id;
						arg_wd = cmd_q.argument;
					end
				end
			end
			S_LCHK: begin
				if (!sv_full) begin
					succ_we = 1'b1;
					sv_we = 1'b1; sv_wa = lk; sv_wd = sv_link;
					pend_we = 1'b1; pend_wa = lk; pend_wd = newp;
					if (pend_rd_q == 8'd0 && !(has_par_q && lk == parent_q)
							&& ref_rd_q != 2'd3) begin
						ref_we = 1'b1; ref_wa = lk; ref_wd = ref_rd_q + 2'd1;
					end
				end
			end
			S_STGT: begin
				if (!hold && start_rd_q != 3'd0) begin
					start_we = 1'b1; start_wa = t_q; start_wd = start_rd_q - 3'd1;
				end
			end
			S_DROP: begin
				sv_we = 1'b1; sv_wa = scan_s_q; sv_wd = '0;
				if (ref_rd_q != 2'd0) begin
					ref_we = 1'b1; ref_wa = scan_s_q; ref_wd = ref_rd_q - 2'd1;
					live_dec = (ref_rd_q == 2'd1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ref_q[i] <= '0;
			end
			next_free_q <= '0;
			live_cnt_q  <= '0;
		end else begin
			if (ref_we) ref_q[ref_wa] <= ref_wd;
			if (live_inc) live_cnt_q <= live_cnt_q + CW'(1);
			else if (live_dec) live_cnt_q <= live_cnt_q - CW'(1);
			if (alloc_ok) next_free_q <= ptr_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (sv_we) sv_q[sv_wa] <= sv_wd;
		if (start_we) start_q[start_wa] <= start_wd;
		if (pend_we) pend_q[pend_wa] <= pend_wd;
		if (info_we) begin
			tcnt_q[info_wa] <= tcnt_wd;
			grp_q[info_wa]  <= grp_wd;
			func_q[info_wa] <= func_wd;
			arg_q[info_wa]  <= arg_wd;
		end
		if (succ_we) succ_q[lk][j_free] <= h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dep_i_q     <= '0;
			nl_q        <= '0;
			link_k_q    <= '0;
			par_phase_q <= 1'b0;
			has_par_q   <= 1'b0;
			ret_link_q  <= 1'b0;
			disp_h_q    <= 1'b0;
			scan_sv_q   <= '0;
			emit_q      <= '0;
			status_q    <= ST_OK;
			newh_q      <= '0;
			ptr_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q   <= S_EXEC;
						emit_q    <= '0;
						status_q  <= ST_OK;
						newh_q    <= '0;
						has_par_q <= 1'b0;
						disp_h_q  <= 1'b0;
						dep_i_q   <= '0;
						nl_q      <= '0;
					end
				end
				S_EXEC: begin
					state_q <= S_FIN;
					if (cmd_q.action == ACT_CREATE) begin
						if (cmd_q.bad_count) status_q <= ST_BAD_COUNT;
						else state_q <= S_DEPS;
					end else if (cmd_q.action == ACT_DONE || cmd_q.action == ACT_RELEASE) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					state_q <= S_FIN;
					if (cmd_q.action == ACT_DONE && ref_rd_q != 2'd0 && pend_rd_q == 8'd1) begin
						scan_s_q   <= hd;
						scan_sv_q  <= sv_rd_q;
						ret_link_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_DEPS: begin
					if (dep_i_q != cmd_q.dep_n) begin
						state_q <= S_DCHK;
					end else if (32'(live_cnt_q) + ((cmd_q.dep_n == 3'd0) ? 2 : 1) > SLOTS) begin
						status_q <= ST_FULL;
						state_q  <= S_FIN;
					end else begin
						par_phase_q <= (cmd_q.dep_n == 3'd0);
						ptr_q       <= next_free_q;
						state_q     <= S_ALLOC;
					end
				end
				S_DCHK: begin
					if (ref_rd_q != 2'd0) begin
						list_q[nl_q[1:0]] <= d_dep;
						nl_q <= nl_q + 3'd1;
					end
					dep_i_q <= dep_i_q + 3'd1;
					state_q <= S_DEPS;
				end
				S_ALLOC: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					ptr_q   <= ptr_nx;
					state_q <= S_ALLOC;
					if (ref_rd_q == 2'd0) begin
						if (par_phase_q) begin
							list_q[0]   <= ptr_q;
							nl_q        <= 3'd1;
							parent_q    <= ptr_q;
							has_par_q   <= 1'b1;
							par_phase_q <= 1'b0;
						end else begin
							h_q      <= ptr_q;
							t_q      <= ptr_q;
							link_k_q <= '0;
							if (nl_q == 3'd0) begin
								disp_h_q <= 1'b1;
								newh_q   <= 6'(ptr_q);
								state_q  <= S_HWAIT;
							end else begin
								state_q <= S_LINK;
							end
						end
					end
				end
				S_HWAIT: begin
					state_q <= S_FIN;
				end
				S_LINK: begin
					state_q <= S_LCHK;
				end
				S_LCHK: begin
					if (sv_full) begin
						status_q <= ST_SUCC_FULL;
						state_q  <= S_FIN;
					end else if (newp == 8'd0) begin
						scan_s_q   <= lk;
						scan_sv_q  <= sv_link;
						ret_link_q <= 1'b1;
						state_q    <= S_SCAN;
					end else if (link_last) begin
						newh_q  <= 6'(h_q);
						state_q <= S_FIN;
					end else begin
						link_k_q <= link_k_q + 2'd1;
						state_q  <= S_LINK;
					end
				end
				S_SCAN: begin
					if (!sc_any) begin
						state_q <= S_DROP;
					end else begin
						scan_sv_q[sc_i] <= 1'b0;
						state_q         <= S_SREAD;
					end
				end
				S_SREAD: begin
					t_q     <= succ_rd_q;
					state_q <= S_STGT;
				end
				S_STGT: begin
					if (!hold) begin
						if (push) emit_q <= emit_q + EW'(1);
						state_q <= S_SCAN;
					end
				end
				S_DROP: begin
					if (!ret_link_q) begin
						state_q <= S_FIN;
					end else if (link_last) begin
						newh_q  <= 6'(h_q);
						state_q <= S_FIN;
					end else begin
						link_k_q <= link_k_q + 2'd1;
						state_q  <= S_LINK;
					end
				end
				S_FIN: begin
					if (push_ok) begin
						if (disp_h_q) disp_h_q <= 1'b0;
						else state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) cmd_q <= cmd;
	end

	// result queue
	assign result_valid = (of_cnt_q != 2'd0);
	assign result       = of_q[of_rd_q];
	assign pop          = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_wr_q  <= 1'b0;
			of_rd_q  <= 1'b0;
			of_cnt_q <= 2'd0;
		end else begin
			if (push && push_ok) of_wr_q <= ~of_wr_q;
			if (pop) of_rd_q <= ~of_rd_q;
			if (push && push_ok && !pop) of_cnt_q <= of_cnt_q + 2'd1;
			else if (pop && !(push && push_ok)) of_cnt_q <= of_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && push_ok) of_q[of_wr_q] <= push_d;
	end

endmodule

// ===== rtl/core/task_dependency_tracker.sv =====
// ----------------------------------------------------------------------------
// task_dependency_tracker
// Task-set slot table with dependency counting and dispatch of ready sets.
// ----------------------------------------------------------------------------
// channel   dir  handshake                    payload
// item      in   item_valid / item_ready      item_t
// result    out  result_valid / result_ready  result_t
//
// A task done or release reads its slot and, when the set completes, runs the
// successor scan, reading each successor in turn. A create checks its
// dependencies, runs the allocation scan over the slots, links the new set to
// each live dependency and runs a successor scan for each one already complete.
// Reset clears reference counts and the free pointer at once; successor valid
// bits are cleared when a slot is taken. A full result queue holds the
// sequencer; the input queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module task_dependency_tracker import tdt_pkg::*; #(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int SUCCESSORS = DEF_SUCCESSORS,
	parameter int MAX_TASKS  = DEF_MAX_TASKS,
	parameter int DEPS       = DEF_DEPS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	tdt_front #(
		.SLOTS     (SLOTS),
		.MAX_TASKS (MAX_TASKS),
		.DEPS      (DEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	tdt_back #(
		.SLOTS      (SLOTS),
		.SUCCESSORS (SUCCESSORS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== rtl/core/tdt_checker.sv =====
// ----------------------------------------------------------------------------
// tdt_checker
// Port-level checks of the task dependency tracker.
// ----------------------------------------------------------------------------
module tdt_checker import tdt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input item_t   item,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("item dropped or changed before transfer");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed before transfer");

	a_dispatch_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_DISPATCH |->
			!result.last && result.status == ST_OK && result.dispatch_count != 8'd0)
		else $error("malformed dispatch");

	a_ack_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_ACK |->
			result.last && result.dispatch_count == 8'd0 && result.dispatch_handle == 6'd0)
		else $error("malformed acknowledgement");

	a_fail_handle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last && result.status != ST_OK |-> result.new_handle == 6'd0)
		else $error("handle reported on failed create");

endmodule

bind task_dependency_tracker tdt_checker u_tdt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ===== sim/task_dependency_tracker_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_dependency_tracker_check
// Watches the item and result channels of the dependency tracker, keeps its
// own copy of the slot table to work out the dispatches and acknowledgement
// of each item, and compares every result transfer with the oldest expected.
// ----------------------------------------------------------------------------
module task_dependency_tracker_check import tdt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      errors,
	output int      outstanding
);

	localparam int NSLOT = DEF_SLOTS;
	localparam int NSUCC = DEF_SUCCESSORS;

	logic        used   [NSLOT];
	logic [1:0]  refs   [NSLOT];
	logic [2:0]  starts [NSLOT];
	logic [7:0]  pend   [NSLOT];
	logic [7:0]  tcount [NSLOT];
	logic [5:0]  grp    [NSLOT];
	logic [15:0] func   [NSLOT];
	logic [31:0] arg    [NSLOT];
	logic [NSUCC-1:0] succ_v [NSLOT];
	logic [5:0]  succ   [NSLOT][NSUCC];
	logic [5:0]  next_free;

	result_t expected_results[$];
	int      emitted;

	assign outstanding = expected_results.size();

	function automatic bit slot_free(int s);
		return !used[s] || refs[s] == 2'd0;
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic push_dispatch(int s);
		result_t r;
		if (emitted < MAX_RESULTS - 1) begin
			r = '0;
			r.kind = KIND_DISPATCH;
			r.dispatch_handle = s[5:0];
			r.dispatch_function = func[s];
			r.dispatch_argument = arg[s];
			r.dispatch_count = tcount[s];
			r.dispatch_group = grp[s];
			expected_results.push_back(r);
			emitted++;
		end
	endtask

	function automatic int take_slot();
		int s;
		s = next_free;
		for (int i = 0; i < NSLOT; i++) begin
			if (slot_free(s))
				break;
			s = (s + 1) % NSLOT;
		end
		used[s] = 1'b1;
		succ_v[s] = '0;
		next_free = 6'((s + 1) % NSLOT);
		return s;
	endfunction

	task automatic finish_task(int s);
		int t;
		if (pend[s] == 8'd0)
			return;
		pend[s]--;
		if (pend[s] != 8'd0)
			return;
		for (int i = 0; i < NSUCC; i++) begin
			if (succ_v[s][i]) begin
				t = succ[s][i];
				succ_v[s][i] = 1'b0;
				if (starts[t] != 3'd0) begin
					starts[t]--;
					if (starts[t] == 3'd0)
						push_dispatch(t);
				end
			end
		end
		if (refs[s] != 2'd0)
			refs[s]--;
	endtask

	task automatic create_set(item_t it, output logic [1:0] st, output logic [5:0] nh);
		int deps[4];
		int dc, nl, nfree, need, parent, h, d, j;
		logic [5:0] dh[4];
		logic [7:0] prev;
		st = ST_OK;
		nh = '0;
		nl = 0;
		nfree = 0;
		parent = NSLOT;
		dh = '{it.dep_first, it.dep_second, it.dep_third, it.dep_fourth};
		if (it.task_count == 8'd0 || it.task_count > DEF_MAX_TASKS) begin
			st = ST_BAD_COUNT;
			return;
		end
		dc = (it.dep_count > DEF_DEPS) ? DEF_DEPS : it.dep_count;
		for (int i = 0; i < dc; i++)
			if (!slot_free(dh[i]))
				deps[nl++] = dh[i];
		need = (dc == 0) ? 2 : 1;
		for (int i = 0; i < NSLOT; i++)
			if (slot_free(i))
				nfree++;
		if (nfree < need) begin
			st = ST_FULL;
			return;
		end
		if (dc == 0) begin
			parent = take_slot();
			pend[parent] = 0;
			refs[parent] = 1;
			starts[parent] = 0;
			grp[parent] = it.group;
			func[parent] = 0;
			arg[parent] = 0;
			tcount[parent] = 0;
			deps[0] = parent;
			nl = 1;
		end
		h = take_slot();
		starts[h] = 3'(nl);
		refs[h] = 2;
		func[h] = it.function_id;
		arg[h] = it.argument;
		tcount[h] = it.task_count;
		pend[h] = it.task_count;
		grp[h] = it.group;
		for (int i = 0; i < nl; i++) begin
			d = deps[i];
			prev = pend[d];
			for (j = 0; j < NSUCC; j++)
				if (!succ_v[d][j])
					break;
			if (j == NSUCC) begin
				st = ST_SUCC_FULL;
				return;
			end
			if (pend[d] != 8'd255)
				pend[d]++;
			if (prev == 8'd0 && d != parent && refs[d] != 2'd3)
				refs[d]++;
			succ[d][j] = 6'(h);
			succ_v[d][j] = 1'b1;
			finish_task(d);
		end
		if (nl == 0)
			push_dispatch(h);
		nh = 6'(h);
	endtask

	task automatic predict_item(item_t it);
		result_t ack;
		logic [1:0] st;
		logic [5:0] nh;
		emitted = 0;
		st = ST_OK;
		nh = '0;
		case (it.action)
			ACT_CREATE: begin
				create_set(it, st, nh);
				if (st != ST_OK)
					nh = '0;
			end
			ACT_DONE: begin
				if (!slot_free(it.handle))
					finish_task(it.handle);
			end
			ACT_RELEASE: begin
				if (!slot_free(it.handle) && refs[it.handle] != 2'd0)
					refs[it.handle]--;
			end
			default: ;
		endcase
		ack = '0;
		ack.kind = KIND_ACK;
		ack.status = st;
		ack.new_handle = nh;
		ack.last = 1'b1;
		expected_results.push_back(ack);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				used[i] = 1'b0;
				refs[i] = '0;
				succ_v[i] = '0;
			end
			next_free = '0;
		end else begin
			if (item_valid && item_ready)
				predict_item(item);
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected result %h", result));
				end else begin
					exp_r = expected_results.pop_front();
					if (result.kind !== exp_r.kind)
						report($sformatf("kind %b, want %b", result.kind, exp_r.kind));
					if (result.status !== exp_r.status)
						report($sformatf("status %0d, want %0d", result.status, exp_r.status));
					if (result.new_handle !== exp_r.new_handle)
						report($sformatf("new_handle %0d, want %0d",
							result.new_handle, exp_r.new_handle));
					if (result.dispatch_handle !== exp_r.dispatch_handle)
						report($sformatf("dispatch_handle %0d, want %0d",
							result.dispatch_handle, exp_r.dispatch_handle));
					if (result.dispatch_function !== exp_r.dispatch_function)
						report($sformatf("dispatch_function %h, want %h",
							result.dispatch_function, exp_r.dispatch_function));
					if (result.dispatch_argument !== exp_r.dispatch_argument)
						report($sformatf("dispatch_argument %h, want %h",
							result.dispatch_argument, exp_r.dispatch_argument));
					if (result.dispatch_count !== exp_r.dispatch_count)
						report($sformatf("dispatch_count %0d, want %0d",
							result.dispatch_count, exp_r.dispatch_count));
					if (result.dispatch_group !== exp_r.dispatch_group)
						report($sformatf("dispatch_group %0d, want %0d",
							result.dispatch_group, exp_r.dispatch_group));
					if (result.last !== exp_r.last)
						report($sformatf("last %b, want %b", result.last, exp_r.last));
				end
			end
		end
	end

	initial errors = 0;

endmodule

// ===== sim/task_dependency_tracker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_dependency_tracker_test
// Drives directed and random create, task-done and release transfers into
// the dependency tracker under changing idle patterns on both channels; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module task_dependency_tracker_test;
	import tdt_pkg::*;

	localparam int RANDOM_ITEMS = 350;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	int      errors;
	int      outstanding;
	int      send_idle = 36;
	int      recv_idle = 58;
	logic [5:0] recent[$];

	always #6 clk = ~clk;

	task_dependency_tracker u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	task_dependency_tracker_check u_check (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.errors(errors), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			result_ready <= ($urandom_range(99) >= recv_idle);
			if (result_valid && result_ready && result.kind == KIND_ACK
					&& result.status == ST_OK && result.new_handle != 6'd0) begin
				recent.push_back(result.new_handle);
				if (recent.size() > 12)
					void'(recent.pop_front());
			end
		end
	end

	function automatic logic [5:0] pick_handle();
		if (recent.size() != 0 && $urandom_range(9) < 8)
			return recent[$urandom_range(recent.size() - 1)];
		return 6'($urandom);
	endfunction

	task automatic send(item_t it);
		if ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	function automatic item_t random_item();
		item_t it;
		int r;
		it = '0;
		it.group = 6'($urandom);
		it.function_id = 16'($urandom);
		it.argument = $urandom;
		it.dep_first = pick_handle();
		it.dep_second = pick_handle();
		it.dep_third = pick_handle();
		it.dep_fourth = pick_handle();
		it.handle = pick_handle();
		r = $urandom_range(99);
		if (r < 40) begin
			it.action = ACT_CREATE;
			it.task_count = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(3, 1));
			it.dep_count = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4));
		end else if (r < 80) begin
			it.action = ACT_DONE;
		end else if (r < 97) begin
			it.action = ACT_RELEASE;
		end else begin
			it.action = 2'd3;
			it.task_count = 8'($urandom);
			it.dep_count = 3'($urandom);
		end
		return it;
	endfunction

	function automatic item_t make_create(logic [7:0] tc, logic [2:0] dc, logic [5:0] d0);
		item_t it;
		it = '0;
		it.action = ACT_CREATE;
		it.group = 6'($urandom);
		it.function_id = 16'($urandom);
		it.argument = $urandom;
		it.task_count = tc;
		it.dep_count = dc;
		it.dep_first = d0;
		it.dep_second = d0 + 6'd1;
		it.dep_third = d0 + 6'd2;
		it.dep_fourth = d0 + 6'd3;
		return it;
	endfunction

	initial begin
		item_t it;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: task count extremes, dead and live deps, done/release edge cases
		send(make_create(8'd0, 3'd0, 6'd0));
		send(make_create(8'd129, 3'd0, 6'd0));
		send(make_create(8'd255, 3'd7, 6'd63));
		send(make_create(8'd1, 3'd0, 6'd0));
		send(make_create(8'd128, 3'd4, 6'd60));
		send(make_create(8'd2, 3'd0, 6'd63));
		send(make_create(8'd1, 3'd1, 6'd3));
		send(make_create(8'd1, 3'd7, 6'd2));
		send(make_create(8'd3, 3'd2, 6'd0));
		it = '1;
		it.action = ACT_CREATE;
		it.task_count = 8'd128;
		it.dep_count = 3'd4;
		send(it);
		it = '0;
		it.action = ACT_DONE;
		it.handle = 6'd50;
		send(it);
		it.handle = 6'd3;
		send(it);
		send(it);
		it.handle = 6'd5;
		send(it);
		it.action = ACT_RELEASE;
		it.handle = 6'd40;
		send(it);
		it.handle = 6'd3;
		send(it);
		it = '1;
		send(it);
		it.action = ACT_RELEASE;
		send(it);
		it.action = ACT_DONE;
		send(it);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				send_idle = 58;
				recv_idle = 36;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			send(random_item());
		end
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("[task_dependency_tracker] OK");
		else
			$display("[task_dependency_tracker] ERROR");
		$finish;
	end

	initial begin
		#30ms;
		$display("[task_dependency_tracker] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tdt_pkg.sv
rtl/core/tdt_front.sv
rtl/core/tdt_back.sv
rtl/core/task_dependency_tracker.sv
rtl/core/tdt_checker.sv
sim/task_dependency_tracker_check.sv
sim/task_dependency_tracker_test.sv
